// File: sv/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_ONEHOT0_CLKD(lbl, clk, rst_n, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(sig)) else $error(msg);
`else
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg)
`define ASSERT_ONEHOT0_CLKD(lbl, clk, rst_n, sig, msg)
`endif

`endif

// File: sv/rwv_pkg.sv
`default_nettype none

package rwv_pkg;

    localparam int RING_DEPTH = 128;
    localparam int PHASE_BITS = 16;

    localparam int RING_AW   = $clog2(RING_DEPTH);
    localparam int FILL_W    = $clog2(RING_DEPTH + 1);
    localparam int SLOT_W    = RING_AW + 2;

    localparam int SAMPLE_W  = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int AMP_W     = 16;
    localparam int AVG_W     = 24;
    localparam int AVG_FRAC  = 8;
    localparam int AUDIO_W   = 24;

    localparam int VALUE_CLAMP = 1000;
    localparam int VALUE_W     = $clog2(VALUE_CLAMP + 1);

    localparam int AVG_KEEP    = 9;
    localparam int AVG_ROUND   = 5;
    localparam int AVG_DIVISOR = 10;
    localparam int AVG_BIAS    = 256;
    localparam int AVG_NUM_W   = AVG_W + 4;
    localparam logic [AVG_W-1:0] AVG_MAX = {AVG_W{1'b1}};

    // divide by ten as multiply by ceil(2^31 / 10), exact for numerators below 2^30
    localparam int AVG_RECIP_SHIFT = 31;
    localparam int AVG_PROD_W      = 2 * AVG_NUM_W;
    localparam logic [AVG_NUM_W-1:0] AVG_RECIP =
        AVG_NUM_W'(((64'd1 << AVG_RECIP_SHIFT) + 64'(AVG_DIVISOR) - 64'd1)
                   / 64'(AVG_DIVISOR));

    localparam int DEN_SHIFT = 7;
    localparam int PROD1_W   = AVG_W + AMP_W;
    localparam int DIV_NUM_W = PROD1_W + CFG_W;
    localparam int DIV_DEN_W = AVG_W + DEN_SHIFT;

    localparam int AUDIO_POS_MAG = 2 ** (AUDIO_W - 1) - 1;
    localparam int AUDIO_NEG_MAG = 2 ** (AUDIO_W - 1);

    localparam logic [CFG_W-1:0] VOLUME_RESET = 16'd32768;
    localparam logic [CFG_W-1:0] PEAK_RESET   = 16'd32768;
    localparam logic [CFG_W-1:0] ATTACK_RESET = 16'd32768;
    localparam logic [CFG_W-1:0] REL_RESET    = 16'd32768;
    localparam logic [CFG_W-1:0] FREL_RESET   = 16'd32768;
    localparam logic [CFG_W-1:0] PSTEP_RESET  = 16'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MASTER_VOLUME     = 3'd0,
        REG_PEAK_AMPLITUDE    = 3'd1,
        REG_ATTACK_STEP       = 3'd2,
        REG_RELEASE_STEP      = 3'd3,
        REG_FAST_RELEASE_STEP = 3'd4,
        REG_PHASE_STEP        = 3'd5
    } cfg_reg_t;

    typedef enum logic {
        REQ_PUSH   = 1'b0,
        REQ_RENDER = 1'b1
    } req_type_t;

    typedef enum logic [1:0] {
        NOTE_HELD          = 2'd0,
        NOTE_RELEASED      = 2'd1,
        NOTE_FAST_RELEASED = 2'd2,
        NOTE_IDLE          = 2'd3
    } note_state_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_PUSH,
        ST_PUSH_WAIT,
        ST_ENV,
        ST_READ,
        ST_MUL1,
        ST_MUL2,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic push_write;
        logic div_start;
        logic avg_load;
        logic env_step;
        logic calc_diff;
        logic mul1;
        logic mul2;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic is_push;
        logic is_idle_note;
        logic avg_zero;
        logic div_busy;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// File: sv/rwv_if.sv
`default_nettype none

interface rwv_req_if;
    import rwv_pkg::*;
    logic                valid;
    logic                ready;
    logic                req_type;
    logic [SAMPLE_W-1:0] distance;
    logic [1:0]          note_state;

    modport source (output valid, output req_type, output distance, output note_state,
                    input ready);
    modport sink   (input valid, input req_type, input distance, input note_state,
                    output ready);
endinterface

interface rwv_rsp_if;
    import rwv_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [AUDIO_W-1:0] audio_out;
    logic                      note_ended;

    modport source (output valid, output audio_out, output note_ended, input ready);
    modport sink   (input valid, input audio_out, input note_ended, output ready);
endinterface

interface rwv_cfg_if;
    import rwv_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: sv/ring_wavetable_voice_with_envelope.sv
// channel  dir  payload                                          handshake
// req      in   req_type[0], distance[15:0], note_state[1:0]     valid/ready
// rsp      out  audio_out[23:0] signed, note_ended               valid/ready
// cfg      in   index[2:0], data[15:0]                           valid/ready, ready tied high
//
// Render: decode, envelope step, ring read, two multiplies, then the 56-step restoring
// divider for the output scaling, then the output state; a zero average skips the divider.
// Idle note: decode goes straight to the output state. Push: ring write, then average load.
// One transaction at a time; a finished result waits in the rsp register while the next
// req is taken, and a render stalls in its output state until that register is free.
// Reset loads register defaults and clears pointers, average, envelope and phase.
`default_nettype none

`include "assert_macros.svh"

module ring_wavetable_voice_with_envelope (
    input  logic      clk,
    input  logic      rst_n,
    rwv_req_if.sink   req,
    rwv_rsp_if.source rsp,
    rwv_cfg_if.sink   cfg
);
    import rwv_pkg::*;

    cmd_t       cmd;
    status_t    status;
    logic       req_ready;
    logic [7:0] cmd_excl;

    rwv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    rwv_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .req_type   (req.req_type),
        .distance   (req.distance),
        .note_state (req.note_state),
        .cfg_valid  (cfg.valid),
        .cfg_ready  (cfg.ready),
        .cfg_index  (cfg.index),
        .cfg_data   (cfg.data),
        .rsp_valid  (rsp.valid),
        .rsp_ready  (rsp.ready),
        .audio_out  (rsp.audio_out),
        .note_ended (rsp.note_ended)
    );

    assign req.ready = req_ready;

    assign cmd_excl = {cmd.capture, cmd.push_write, cmd.avg_load, cmd.env_step,
                       cmd.calc_diff, cmd.mul1, cmd.mul2, cmd.out_load};

    `ASSERT_CLKD(a_one_in_flight, clk, rst_n, (req.valid && req.ready) |=> !req.ready, "req taken while busy")
    `ASSERT_CLKD(a_no_overwrite, clk, rst_n, cmd.out_load |-> status.out_free, "rsp overwritten")
    `ASSERT_CLKD(a_div_idle_start, clk, rst_n, cmd.div_start |-> !status.div_busy, "divider restarted")
    `ASSERT_ONEHOT0_CLKD(a_cmd_excl, clk, rst_n, cmd_excl, "conflicting datapath commands")

endmodule

`default_nettype wire

// File: sv/rwv_ram.sv
`default_nettype none

module rwv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: sv/rwv_div.sv
`default_nettype none

module rwv_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [rwv_pkg::DIV_NUM_W-1:0] dividend,
    input  logic [rwv_pkg::DIV_DEN_W-1:0] divisor,
    output logic                          busy,
    output logic                          done,
    output logic [rwv_pkg::DIV_NUM_W-1:0] quotient
);
    import rwv_pkg::*;

    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DIV_DEN_W:0]   rem_sh;
    logic [DIV_DEN_W:0]   rem_sub;
    logic                 fits;

    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[DIV_NUM_W-1]};
        rem_sub  = rem_sh - {1'b0, den_reg};
        fits     = (rem_sh >= {1'b0, den_reg});
        rem_next = fits ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
        quo_next = {quo_reg[DIV_NUM_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// File: sv/rwv_dp.sv
`default_nettype none

module rwv_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  rwv_pkg::cmd_t                      cmd,
    output rwv_pkg::status_t                   status,
    input  logic                               req_type,
    input  logic [rwv_pkg::SAMPLE_W-1:0]       distance,
    input  logic [1:0]                         note_state,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rwv_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rwv_pkg::CFG_W-1:0]          cfg_data,
    output logic                               rsp_valid,
    input  logic                               rsp_ready,
    output logic signed [rwv_pkg::AUDIO_W-1:0] audio_out,
    output logic                               note_ended
);
    import rwv_pkg::*;

    localparam int IDX_PROD_W = PHASE_BITS + RING_AW + 1;

    logic [CFG_W-1:0]      vol_reg, peak_reg, att_reg, rel_reg, frel_reg, pstep_reg;

    req_type_t             req_reg;
    note_state_t           ns_reg;
    logic [SAMPLE_W-1:0]   dist_reg;

    logic [RING_AW-1:0]    wp_reg, wp_next;
    logic [FILL_W-1:0]     fill_reg;
    logic [AVG_W-1:0]      avg_reg, avg_next;
    logic [AMP_W-1:0]      amp_reg, amp_next;
    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic [RING_AW-1:0]    idx_reg, idx_next;
    logic                  ended_reg, ended_next;

    logic                  neg_reg, neg_next;
    logic [AVG_W-1:0]      mag_reg, mag_next;
    logic [PROD1_W-1:0]    prod1_reg;
    logic [DIV_NUM_W-1:0]  prod2_reg;

    logic                  out_valid_reg;
    logic [AUDIO_W-1:0]    audio_reg, audio_next;
    logic                  out_ended_reg;

    logic [AMP_W:0]        amp_rise;
    logic [AMP_W-1:0]      amp_held, amp_fall, fall_step;
    logic [IDX_PROD_W-1:0] idx_prod;
    logic [SLOT_W-1:0]     slot_sum, slot_red;
    logic [SAMPLE_W-1:0]   ram_rdata;
    logic [VALUE_W-1:0]    value;
    logic [AVG_W-1:0]      scaled;
    logic [AVG_NUM_W-1:0]  avg_num, avg_num_reg;
    logic [AVG_PROD_W-1:0] avg_prod;
    logic [AVG_W+1:0]      avg_sum;

    logic [DIV_NUM_W-1:0]  div_num, div_quot;
    logic [DIV_DEN_W-1:0]  div_den;
    logic                  div_busy, div_done;

    // envelope
    always_comb
    begin
        amp_rise  = (amp_reg < peak_reg) ? ({1'b0, amp_reg} + {1'b0, att_reg})
                                          : {1'b0, amp_reg};
        amp_held  = (amp_rise > {1'b0, peak_reg}) ? peak_reg : amp_rise[AMP_W-1:0];
        fall_step = (ns_reg == NOTE_RELEASED) ? rel_reg : frel_reg;
        amp_fall  = (amp_reg > fall_step) ? (amp_reg - fall_step) : '0;
        amp_next   = amp_reg;
        ended_next = 1'b0;
        case (ns_reg)
            NOTE_HELD:
            begin
                amp_next = amp_held;
            end
            NOTE_RELEASED, NOTE_FAST_RELEASED:
            begin
                if (amp_reg != '0)
                begin
                    amp_next = amp_fall;
                end
                else
                begin
                    ended_next = 1'b1;
                end
            end
            default:
            begin
                amp_next = amp_reg;
            end
        endcase
    end

    // table index and ring slot, oldest entry first
    always_comb
    begin
        phase_next = phase_reg + PHASE_BITS'(pstep_reg);
        idx_prod   = IDX_PROD_W'(phase_reg) * IDX_PROD_W'(RING_DEPTH);
        idx_next   = idx_prod[PHASE_BITS +: RING_AW];
        slot_sum   = SLOT_W'(wp_reg) + SLOT_W'(RING_DEPTH) - SLOT_W'(fill_reg)
                   + SLOT_W'(idx_next);
        if (slot_sum >= SLOT_W'(2 * RING_DEPTH))
        begin
            slot_red = slot_sum - SLOT_W'(2 * RING_DEPTH);
        end
        else if (slot_sum >= SLOT_W'(RING_DEPTH))
        begin
            slot_red = slot_sum - SLOT_W'(RING_DEPTH);
        end
        else
        begin
            slot_red = slot_sum;
        end
        wp_next = (wp_reg == RING_AW'(RING_DEPTH - 1)) ? '0 : (wp_reg + 1'b1);
    end

    rwv_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (cmd.push_write),
        .waddr (wp_reg),
        .wdata (dist_reg),
        .re    (cmd.env_step),
        .raddr (slot_red[RING_AW-1:0]),
        .rdata (ram_rdata)
    );

    // value and distance from the average
    always_comb
    begin
        if (FILL_W'(idx_reg) >= fill_reg)
        begin
            value = '0;
        end
        else if (ram_rdata < SAMPLE_W'(VALUE_CLAMP))
        begin
            value = ram_rdata[VALUE_W-1:0];
        end
        else
        begin
            value = VALUE_W'(VALUE_CLAMP);
        end
        scaled   = AVG_W'({value, {AVG_FRAC{1'b0}}});
        neg_next = (avg_reg > scaled);
        mag_next = neg_next ? (avg_reg - scaled) : (scaled - avg_reg);
    end

    // average update by reciprocal multiply; the divider scales the output
    always_comb
    begin
        avg_num  = AVG_NUM_W'(avg_reg) * AVG_NUM_W'(AVG_KEEP)
                 + AVG_NUM_W'({dist_reg, {AVG_FRAC{1'b0}}})
                 + AVG_NUM_W'(AVG_ROUND);
        avg_prod = AVG_PROD_W'(avg_num_reg) * AVG_PROD_W'(AVG_RECIP);
        avg_sum  = (AVG_W+2)'(avg_prod[AVG_PROD_W-1:AVG_RECIP_SHIFT])
                 + (AVG_W+2)'(AVG_BIAS);
        avg_next = (avg_sum > (AVG_W+2)'(AVG_MAX)) ? AVG_MAX : avg_sum[AVG_W-1:0];
        div_num  = prod2_reg;
        div_den  = {avg_reg, {DEN_SHIFT{1'b0}}};
    end

    rwv_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb
    begin
        if ((ns_reg == NOTE_IDLE) || (avg_reg == '0))
        begin
            audio_next = '0;
        end
        else if (neg_reg)
        begin
            audio_next = (div_quot >= DIV_NUM_W'(AUDIO_NEG_MAG)) ? AUDIO_W'(AUDIO_NEG_MAG)
                                                                : -div_quot[AUDIO_W-1:0];
        end
        else
        begin
            audio_next = (div_quot > DIV_NUM_W'(AUDIO_POS_MAG)) ? AUDIO_W'(AUDIO_POS_MAG)
                                                               : div_quot[AUDIO_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vol_reg       <= VOLUME_RESET;
            peak_reg      <= PEAK_RESET;
            att_reg       <= ATTACK_RESET;
            rel_reg       <= REL_RESET;
            frel_reg      <= FREL_RESET;
            pstep_reg     <= PSTEP_RESET;
            wp_reg        <= '0;
            fill_reg      <= '0;
            avg_reg       <= '0;
            amp_reg       <= '0;
            phase_reg     <= '0;
            ended_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_MASTER_VOLUME:     vol_reg   <= cfg_data;
                    REG_PEAK_AMPLITUDE:    peak_reg  <= cfg_data;
                    REG_ATTACK_STEP:       att_reg   <= cfg_data;
                    REG_RELEASE_STEP:      rel_reg   <= cfg_data;
                    REG_FAST_RELEASE_STEP: frel_reg  <= cfg_data;
                    REG_PHASE_STEP:        pstep_reg <= cfg_data;
                    default:               ;
                endcase
            end
            if (cmd.push_write)
            begin
                wp_reg <= wp_next;
                if (fill_reg < FILL_W'(RING_DEPTH))
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            if (cmd.avg_load)
            begin
                avg_reg <= avg_next;
            end
            if (cmd.capture)
            begin
                ended_reg <= 1'b0;
            end
            else if (cmd.env_step)
            begin
                amp_reg   <= amp_next;
                phase_reg <= phase_next;
                ended_reg <= ended_next;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg  <= req_type_t'(req_type);
            dist_reg <= distance;
            ns_reg   <= note_state_t'(note_state);
        end
        if (cmd.push_write)
        begin
            avg_num_reg <= avg_num;
        end
        if (cmd.env_step)
        begin
            idx_reg <= idx_next;
        end
        if (cmd.calc_diff)
        begin
            neg_reg <= neg_next;
            mag_reg <= mag_next;
        end
        if (cmd.mul1)
        begin
            prod1_reg <= PROD1_W'(mag_reg) * PROD1_W'(amp_reg);
        end
        if (cmd.mul2)
        begin
            prod2_reg <= DIV_NUM_W'(prod1_reg) * DIV_NUM_W'(vol_reg);
        end
        if (cmd.out_load)
        begin
            audio_reg     <= audio_next;
            out_ended_reg <= ended_reg;
        end
    end

    always_comb
    begin
        status.is_push      = (req_reg == REQ_PUSH);
        status.is_idle_note = (ns_reg == NOTE_IDLE);
        status.avg_zero     = (avg_reg == '0);
        status.div_busy     = div_busy;
        status.div_done     = div_done;
        status.out_free     = !out_valid_reg || rsp_ready;
    end

    assign cfg_ready  = 1'b1;
    assign rsp_valid  = out_valid_reg;
    assign audio_out  = audio_reg;
    assign note_ended = out_ended_reg;

endmodule

`default_nettype wire

// File: sv/rwv_ctrl.sv
`default_nettype none

module rwv_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  rwv_pkg::status_t status,
    output rwv_pkg::cmd_t    cmd
);
    import rwv_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (status.is_push)
                begin
                    state_next = ST_PUSH;
                end
                else if (status.is_idle_note)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_ENV;
                end
            end
            ST_PUSH:
            begin
                cmd.push_write = 1'b1;
                state_next     = ST_PUSH_WAIT;
            end
            ST_PUSH_WAIT:
            begin
                cmd.avg_load = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_ENV:
            begin
                cmd.env_step = 1'b1;
                state_next   = ST_READ;
            end
            ST_READ:
            begin
                cmd.calc_diff = 1'b1;
                state_next    = ST_MUL1;
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = status.avg_zero ? ST_OUT : ST_DIV_START;
            end
            ST_DIV_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sim/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rwv_pkg::*;

    localparam int QUIET_CYCLES = 100;
    localparam int HOLD_CYCLES  = 500;
    localparam int STALL_LIMIT  = 5000;
    localparam int PHASE_ITEMS  = 225;

    // indexes past the register file, ignored by the block
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        req_type_t           kind;
        logic [SAMPLE_W-1:0] dist_val;
        note_state_t         note;
    } voice_req_t;

    typedef struct packed {
        logic signed [AUDIO_W-1:0] audio;
        logic                      ended;
    } frame_t;

    class voice_tracker;
        logic [CFG_W-1:0]      volume;
        logic [CFG_W-1:0]      peak;
        logic [CFG_W-1:0]      attack;
        logic [CFG_W-1:0]      rel_fall;
        logic [CFG_W-1:0]      fast_fall;
        logic [CFG_W-1:0]      phase_inc;
        logic [SAMPLE_W-1:0]   ring [RING_DEPTH];
        logic [RING_AW-1:0]    wr_ptr;
        int unsigned           fill;
        logic [AVG_W-1:0]      avg;
        int unsigned           amp;
        logic [PHASE_BITS-1:0] phase;
        frame_t                frames_due [$];
        int mismatches, results, pushes, renders, idle_ticks, note_ends;
        int clipped, writes, avg_pegged, ring_laps;

        function new();
            volume     = VOLUME_RESET;
            peak       = PEAK_RESET;
            attack     = ATTACK_RESET;
            rel_fall   = REL_RESET;
            fast_fall  = FREL_RESET;
            phase_inc  = PSTEP_RESET;
            wr_ptr     = '0;
            fill       = 0;
            avg        = '0;
            amp        = 0;
            phase      = '0;
            foreach (ring[i])
                ring[i] = '0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            writes++;
            case (idx)
                REG_MASTER_VOLUME:     volume    = data;
                REG_PEAK_AMPLITUDE:    peak      = data;
                REG_ATTACK_STEP:       attack    = data;
                REG_RELEASE_STEP:      rel_fall  = data;
                REG_FAST_RELEASE_STEP: fast_fall = data;
                REG_PHASE_STEP:        phase_inc = data;
                default: ;
            endcase
        endfunction

        function void take_request(voice_req_t it);
            longint unsigned     acc;
            longint              num, den, q;
            int unsigned         a, fall, idx, v;
            logic [RING_AW-1:0]  slot;
            frame_t              f;
            if (it.kind == REQ_PUSH)
            begin
                pushes++;
                ring[wr_ptr] = it.dist_val;
                if (wr_ptr == RING_AW'(RING_DEPTH - 1))
                    ring_laps++;
                wr_ptr = wr_ptr + 1'b1;
                if (fill < RING_DEPTH)
                    fill++;
                acc = (64'd9 * avg + 64'd256 * it.dist_val + 64'd5) / 64'd10 + 64'd256;
                if (acc > AVG_MAX)
                begin
                    avg = AVG_MAX;
                    avg_pegged++;
                end
                else
                    avg = acc[AVG_W-1:0];
                return;
            end
            renders++;
            f = '0;
            if (it.note == NOTE_IDLE)
            begin
                idle_ticks++;
                frames_due = {frames_due, f};
                return;
            end
            if (it.note == NOTE_HELD)
            begin
                a = amp;
                if (a < peak)
                    a += attack;
                if (a > peak)
                    a = peak;
                amp = a;
            end
            else
            begin
                fall = (it.note == NOTE_RELEASED) ? rel_fall : fast_fall;
                if (amp > 0)
                    amp = (amp > fall) ? amp - fall : 0;
                else
                begin
                    f.ended = 1'b1;
                    note_ends++;
                end
            end
            idx = (32'(phase) * RING_DEPTH) >> PHASE_BITS;
            v = 0;
            if (idx < fill)
            begin
                slot = wr_ptr - RING_AW'(fill) + RING_AW'(idx);
                v = (ring[slot] < VALUE_CLAMP) ? ring[slot] : VALUE_CLAMP;
            end
            if (avg != 0)
            begin
                num = (longint'(v) * 256 - longint'(avg)) * longint'(amp) * longint'(volume);
                den = longint'(avg) * 128;
                q = num / den;
                if (q > AUDIO_POS_MAG)
                begin
                    q = AUDIO_POS_MAG;
                    clipped++;
                end
                if (q < -AUDIO_NEG_MAG)
                begin
                    q = -AUDIO_NEG_MAG;
                    clipped++;
                end
                f.audio = q[AUDIO_W-1:0];
            end
            phase = phase + phase_inc;
            frames_due = {frames_due, f};
        endfunction

        function void match_frame(logic signed [AUDIO_W-1:0] audio, logic ended);
            frame_t want;
            results++;
            if (frames_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %0d: audio=%0d ended=%0b", results, audio, ended);
                return;
            end
            want = frames_due.pop_front();
            if (audio !== want.audio || ended !== want.ended)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch on result %0d: expected audio=%0d ended=%0b,",
                              " got audio=%0d ended=%0b"},
                             results, want.audio, want.ended, audio, ended);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    rwv_req_if req_ch ();
    rwv_rsp_if rsp_ch ();
    rwv_cfg_if cfg_ch ();

    voice_tracker board = new();

    int gap_pct;
    int stall_pct;
    int rsp_hold;
    int items_sent;

    ring_wavetable_voice_with_envelope u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always #2 clk = ~clk;

    task automatic send_req(input voice_req_t it);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= it.kind;
        req_ch.distance   <= it.dist_val;
        req_ch.note_state <= it.note;
        do
            @(posedge clk);
        while (!req_ch.ready);
        board.take_request(it);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic push(input logic [SAMPLE_W-1:0] d);
        send_req(voice_req_t'{REQ_PUSH, d, note_state_t'($urandom_range(0, 3))});
    endtask

    task automatic tick(input note_state_t n);
        send_req(voice_req_t'{REQ_RENDER, SAMPLE_W'($urandom), n});
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_distance();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return SAMPLE_W'($urandom_range(0, 1200));
        if (r < 55)
            return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        return SAMPLE_W'($urandom);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        board.set_reg(idx, data);
        @(negedge clk);
    endtask

    // pushes give no result, so allow one more transaction to finish
    task automatic wait_quiet();
        req_ch.valid <= 1'b0;
        while (board.frames_due.size() != 0)
            @(negedge clk);
        repeat (QUIET_CYCLES) @(negedge clk);
    endtask

    task automatic apply_setting(input logic [CFG_W-1:0] vol, input logic [CFG_W-1:0] pk,
                                 input logic [CFG_W-1:0] att, input logic [CFG_W-1:0] rel,
                                 input logic [CFG_W-1:0] fast, input logic [CFG_W-1:0] pinc,
                                 input logic [CFG_IDX_W-1:0] spare);
        wait_quiet();
        write_reg(REG_MASTER_VOLUME, vol);
        write_reg(REG_PEAK_AMPLITUDE, pk);
        write_reg(REG_ATTACK_STEP, att);
        write_reg(REG_RELEASE_STEP, rel);
        write_reg(REG_FAST_RELEASE_STEP, fast);
        write_reg(REG_PHASE_STEP, pinc);
        write_reg(spare, CFG_W'($urandom));
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic play_phrase();
        int          r;
        note_state_t fade;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            repeat ($urandom_range(1, 8))
                send_req(voice_req_t'{req_type_t'($urandom_range(0, 1)), SAMPLE_W'($urandom),
                                      note_state_t'($urandom_range(0, 3))});
        end
        else if (r < 13)
        begin
            repeat ($urandom_range(90, 110))
                push(SAMPLE_W'($urandom_range(65000, 65535)));
        end
        else
        begin
            repeat ($urandom_range(0, 6))
                push(pick_distance());
            repeat ($urandom_range(1, 20))
            begin
                if ($urandom_range(0, 4) == 0)
                    push(pick_distance());
                tick(NOTE_HELD);
            end
            fade = ($urandom_range(0, 1) != 0) ? NOTE_RELEASED : NOTE_FAST_RELEASED;
            repeat ($urandom_range(1, 15))
                tick(fade);
            repeat ($urandom_range(0, 3))
                tick(NOTE_IDLE);
        end
    endtask

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rsp_hold > 0)
            begin
                rsp_hold--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
                board.match_frame(rsp_ch.audio_out, rsp_ch.note_ended);
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("timeout: %0d cycles without a transaction", idle_cycles);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        int s;
        int target;
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_PUSH;
        req_ch.distance   = '0;
        req_ch.note_state = NOTE_HELD;
        rsp_ch.ready      = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = REG_MASTER_VOLUME;
        cfg_ch.data       = '0;
        gap_pct           = 0;
        stall_pct         = 0;
        rsp_hold          = 0;
        items_sent        = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty ring, envelope edges, note end, idle note
        tick(NOTE_HELD);
        tick(NOTE_RELEASED);
        tick(NOTE_RELEASED);
        tick(NOTE_FAST_RELEASED);
        tick(NOTE_IDLE);
        push(16'd0);
        tick(NOTE_HELD);
        push(16'hFFFF);
        push(16'd1000);
        push(16'd999);
        push(16'd1001);
        tick(NOTE_HELD);
        // phase lands past the fill count
        wait_quiet();
        write_reg(REG_PHASE_STEP, 16'd16384);
        cfg_ch.valid <= 1'b0;
        repeat (4) tick(NOTE_HELD);
        // peak lowered under the current amplitude
        wait_quiet();
        write_reg(REG_PEAK_AMPLITUDE, 16'd16384);
        cfg_ch.valid <= 1'b0;
        tick(NOTE_HELD);
        tick(NOTE_FAST_RELEASED);
        tick(NOTE_FAST_RELEASED);
        tick(NOTE_IDLE);
        push(16'hFFFF);
        push(16'd0);
        tick(NOTE_RELEASED);

        for (s = 0; s < 8; s++)
        begin
            case (s)
                0: apply_setting(16'd32768, 16'd32768, 16'd4096, 16'd2048, 16'd16384, 16'd1,
                                 REG_SPARE_LO);
                1: apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                 REG_SPARE_HI);
                2: apply_setting(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, REG_SPARE_LO);
                3: apply_setting(16'd20000, 16'd30000, 16'd1000, 16'd500, 16'd8000, 16'd512,
                                 REG_SPARE_HI);
                4: apply_setting(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                                 CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                                 REG_SPARE_LO);
                5: apply_setting(16'd32768, 16'd16384, 16'd32768, 16'd1, 16'd32768, 16'd333,
                                 REG_SPARE_HI);
                6: apply_setting(CFG_W'($urandom_range(0, 32768)),
                                 CFG_W'($urandom_range(0, 32768)),
                                 CFG_W'($urandom_range(0, 32768)),
                                 CFG_W'($urandom_range(0, 32768)),
                                 CFG_W'($urandom_range(0, 32768)), CFG_W'($urandom),
                                 REG_SPARE_LO);
                default: apply_setting(16'd32768, 16'd32768, 16'd32768, 16'd32768, 16'd32768,
                                       16'd4096, REG_SPARE_HI);
            endcase
            case (s % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 50; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 50; end
                default: begin gap_pct = 15; stall_pct = 15; end
            endcase
            if (s == 2 || s == 4)
                rsp_hold = HOLD_CYCLES;
            target = items_sent + PHASE_ITEMS;
            if (s == 1)
                repeat (100) push(SAMPLE_W'($urandom_range(65000, 65535)));
            while (items_sent < target)
                play_phrase();
        end

        wait_quiet();
        $display({"covered %0d pushes and %0d renders (%0d idle, %0d note ends,",
                  " %0d clipped), %0d register writes"},
                 board.pushes, board.renders, board.idle_ticks, board.note_ends, board.clipped,
                 board.writes);
        $display({"ring wrapped %0d times, average pinned at its ceiling %0d times,",
                  " %0d of %0d results wrong"},
                 board.ring_laps, board.avg_pegged, board.mismatches, board.results);
        if (board.mismatches == 0 && board.frames_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
